// ===== src/qbe_pkg.sv =====
// ----------------------------------------------------------------------------
// qbe_pkg
// Shared types, character constants and hex digit lookup for the quoted byte
// escaper.
// ----------------------------------------------------------------------------
package qbe_pkg;

    localparam int SEQ_LEN  = 6;
    localparam int BODY_LEN = 4;

    localparam logic [7:0] C_QUOTE    = 8'h22;
    localparam logic [7:0] C_BSLASH   = 8'h5c;
    localparam logic [7:0] C_PRINT_LO = 8'h20;
    localparam logic [7:0] C_PRINT_HI = 8'h7e;
    localparam logic [3:0] C_NIB_MASK = 4'hf;

    // control bytes that have a short escape
    localparam logic [7:0] C_LF  = 8'h0a;
    localparam logic [7:0] C_CR  = 8'h0d;
    localparam logic [7:0] C_TAB = 8'h09;
    localparam logic [7:0] C_BEL = 8'h07;
    localparam logic [7:0] C_BS  = 8'h08;

    localparam logic [7:0] C_CH_N = 8'h6e;
    localparam logic [7:0] C_CH_R = 8'h72;
    localparam logic [7:0] C_CH_T = 8'h74;
    localparam logic [7:0] C_CH_A = 8'h61;
    localparam logic [7:0] C_CH_B = 8'h62;
    localparam logic [7:0] C_CH_X = 8'h78;

    typedef logic [SEQ_LEN-1:0][7:0] t_chars;
    typedef logic [2:0]              t_cnt;

    typedef struct packed {
        t_chars chars;   // chars[0] goes out first
        t_cnt   count;   // 1 to 6
    } t_seq;

    localparam logic [15:0][7:0] C_HEX_DIGITS = {
        8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return C_HEX_DIGITS[nib & C_NIB_MASK];
    endfunction

endpackage

// ===== src/qbe_in_if.sv =====
// ----------------------------------------------------------------------------
// qbe_in_if
// Valid/ready channel carrying one raw string byte and its string marks.
// ----------------------------------------------------------------------------
interface qbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_string;
    logic       last_of_string;
    logic       empty_string;

    modport source (
        output valid, data_byte, first_of_string, last_of_string, empty_string,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_of_string, last_of_string, empty_string,
        output ready
    );
endinterface

// ===== src/qbe_out_if.sv =====
// ----------------------------------------------------------------------------
// qbe_out_if
// Valid/ready channel carrying one character of the escaped text.
// ----------------------------------------------------------------------------
interface qbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ===== src/qbe_decode.sv =====
// ----------------------------------------------------------------------------
// qbe_decode
// Turns one registered input item into its character sequence: optional
// opening quote, escaped body, optional closing quote (empty string: "").
// ----------------------------------------------------------------------------
module qbe_decode (
    input  logic         i_data_byte_vld,
    input  logic [7:0]   i_data_byte,
    input  logic         i_first_of_string,
    input  logic         i_last_of_string,
    input  logic         i_empty_string,
    output qbe_pkg::t_seq o_seq
);
    import qbe_pkg::*;

    logic [BODY_LEN-1:0][7:0] body;
    t_cnt                     bcnt;
    logic [7:0]               esc;
    logic                     has_esc;
    t_cnt                     off;

    always_comb begin
        esc     = '0;
        has_esc = 1'b1;
        case (i_data_byte)
            C_BSLASH: esc = C_BSLASH;
            C_QUOTE:  esc = C_QUOTE;
            C_LF:     esc = C_CH_N;
            C_CR:     esc = C_CH_R;
            C_TAB:    esc = C_CH_T;
            C_BEL:    esc = C_CH_A;
            C_BS:     esc = C_CH_B;
            default:  has_esc = 1'b0;
        endcase

        body = '0;
        if (has_esc) begin
            body[0] = C_BSLASH;
            body[1] = esc;
            bcnt    = 3'd2;
        end else if (i_data_byte inside {[C_PRINT_LO:C_PRINT_HI]}) begin
            body[0] = i_data_byte;
            bcnt    = 3'd1;
        end else begin
            body[0] = C_BSLASH;
            body[1] = C_CH_X;
            body[2] = hex_digit(i_data_byte[7:4]);
            body[3] = hex_digit(i_data_byte[3:0]);
            bcnt    = 3'd4;
        end
    end

    always_comb begin
        o_seq = '0;
        off   = {2'b00, i_first_of_string};
        if (i_empty_string || !i_data_byte_vld) begin
            o_seq.chars[0] = C_QUOTE;
            o_seq.chars[1] = C_QUOTE;
            o_seq.count    = 3'd2;
        end else begin
            if (i_first_of_string) begin
                o_seq.chars[0] = C_QUOTE;
            end
            for (int k = 0; k < BODY_LEN; k++) begin
                if (3'(k) < bcnt) begin
                    o_seq.chars[off + 3'(k)] = body[k];
                end
            end
            if (i_last_of_string) begin
                o_seq.chars[off + bcnt] = C_QUOTE;
            end
            o_seq.count = off + bcnt + {2'b00, i_last_of_string};
        end
    end

endmodule

// ===== src/qbe_serial.sv =====
// ----------------------------------------------------------------------------
// qbe_serial
// Result register: holds one item's character sequence and shifts it out one
// character per accepted output item. Reloads on the cycle the last goes.
// ----------------------------------------------------------------------------
module qbe_serial (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load_valid,
    input  qbe_pkg::t_seq i_seq,
    output logic         o_load_ready,
    qbe_out_if.source    o_out
);
    import qbe_pkg::*;

    t_chars r_chars, n_chars;
    t_cnt   r_left,  n_left;
    logic   r_busy,  n_busy;
    logic   take;
    logic   is_last;

    assign is_last      = (r_left == 3'd1);
    assign take         = r_busy && o_out.ready;
    assign o_load_ready = !r_busy || (take && is_last);

    assign o_out.valid    = r_busy;
    assign o_out.out_byte = r_chars[0];
    assign o_out.out_last = is_last;

    always_comb begin
        n_chars = r_chars;
        n_left  = r_left;
        n_busy  = r_busy;
        if (i_load_valid && o_load_ready) begin
            n_chars = i_seq.chars;
            n_left  = i_seq.count;
            n_busy  = 1'b1;
        end else if (take) begin
            if (is_last) begin
                n_busy = 1'b0;
            end
            n_chars = {8'h00, r_chars[SEQ_LEN-1:1]};
            n_left  = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

endmodule

// ===== src/quoted_byte_escaper.sv =====
// Path: an accepted item passes the input register and the serialiser's result
// register before its first character shows. Throughput: one output character
// per cycle while the output is ready; an item makes 1 to 6 characters (escaped
// body of 1, 2 or 4 plus quotes). The single output serialiser sets the rate; a
// new item is taken in the cycle the previous item's last character is taken.
// Reset: synchronous, active low; clears the input and output valid flags.
// ----------------------------------------------------------------------------
// quoted_byte_escaper
// Streams string bytes and emits their double-quoted, C-style escaped text.
// ----------------------------------------------------------------------------
module quoted_byte_escaper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qbe_in_if.sink    i_in,
    qbe_out_if.source o_out
);
    import qbe_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_first_of_string;
    logic       r_last_of_string;
    logic       r_empty_string;
    logic       load_ready;
    t_seq       seq;

    assign i_in.ready = !r_in_valid || load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_data_byte       <= i_in.data_byte;
            r_first_of_string <= i_in.first_of_string;
            r_last_of_string  <= i_in.last_of_string;
            r_empty_string    <= i_in.empty_string;
        end
    end

    qbe_decode u_decode (
        .i_data_byte_vld   (r_in_valid),
        .i_data_byte       (r_data_byte),
        .i_first_of_string (r_first_of_string),
        .i_last_of_string  (r_last_of_string),
        .i_empty_string    (r_empty_string),
        .o_seq             (seq)
    );

    qbe_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_seq        (seq),
        .o_load_ready (load_ready),
        .o_out        (o_out)
    );

endmodule

// ===== src/qbe_check.sv =====
// ----------------------------------------------------------------------------
// qbe_check
// Port-level checks on the escaper's input and output streams, bound to the top level.
// ----------------------------------------------------------------------------
module qbe_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    import qbe_pkg::*;

    // stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output item changed while stalled");

    // an item's characters come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside one item's characters");

    // mid-item backslash is followed by a legal escape character
    a_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last && i_out_byte == C_BSLASH |=>
            i_out_byte == C_BSLASH || i_out_byte == C_QUOTE ||
            i_out_byte == C_CH_N || i_out_byte == C_CH_R ||
            i_out_byte == C_CH_T || i_out_byte == C_CH_A ||
            i_out_byte == C_CH_B || i_out_byte == C_CH_X)
        else $error("backslash not followed by an escape character");

    // output is idle on the cycle after a reset edge
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

    // input is always ready when nothing is pending downstream
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_in_valid) && $past(i_rst_n) |-> i_in_ready)
        else $error("input stalled with the block empty");

endmodule

bind quoted_byte_escaper qbe_check u_qbe_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);
